// ----- sv/ltc_pkg.sv -----
package ltc_pkg;

  // A clamped displacement magnitude reaches 16 at most, because the code -16 can
  // survive the clamp when the step limit is 16 or more.
  localparam int MAG_W = 5;
  localparam int COORD_W = 10;
  localparam int DELTA_W = 5;
  localparam int CELL_W = 11;
  // Width of the column/row error term ax*(2y-1) - ay*(2c+1) plus headroom.
  localparam int ERR_W = 13;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    MODE_VERT,
    MODE_HORZ,
    MODE_DIAG
  } ltc_mode_t;

  typedef enum logic {
    WALK_IDLE,
    WALK_RUN
  } ltc_walk_state_t;

  typedef struct packed {
    ltc_mode_t mode;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic neg_x;
    logic neg_y;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
  } ltc_cmd_t;

endpackage

// ----- sv/ltc_front.sv -----
module ltc_front #(
  parameter int MAX_STEP = 15
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // start_x [9:0], start_y [19:10], delta_x [24:20], delta_y [29:25], zero fill
  input  logic [ltc_pkg::IN_DATA_W-1:0] s_tdata,
  output logic cmd_vld,
  input  logic cmd_rdy,
  output ltc_pkg::ltc_cmd_t cmd
);
  import ltc_pkg::*;

  localparam logic signed [DELTA_W:0] LIM = (DELTA_W+1)'(MAX_STEP);

  logic signed [DELTA_W:0] dx_ext;
  logic signed [DELTA_W:0] dy_ext;
  logic signed [DELTA_W:0] dx_sat;
  logic signed [DELTA_W:0] dy_sat;
  logic signed [DELTA_W:0] dx_abs;
  logic signed [DELTA_W:0] dy_abs;
  ltc_cmd_t cmd_new;

  assign s_tready = !cmd_vld || cmd_rdy;

  always_comb begin
    dx_ext = {s_tdata[24], s_tdata[24:20]};
    dy_ext = {s_tdata[29], s_tdata[29:25]};

    dx_sat = dx_ext;
    if (dx_ext > LIM) begin
      dx_sat = LIM;
    end else if (dx_ext < -LIM) begin
      dx_sat = -LIM;
    end
    dy_sat = dy_ext;
    if (dy_ext > LIM) begin
      dy_sat = LIM;
    end else if (dy_ext < -LIM) begin
      dy_sat = -LIM;
    end

    dx_abs = dx_sat[DELTA_W] ? -dx_sat : dx_sat;
    dy_abs = dy_sat[DELTA_W] ? -dy_sat : dy_sat;

    cmd_new.start_x = s_tdata[9:0];
    cmd_new.start_y = s_tdata[19:10];
    cmd_new.neg_x = dx_sat[DELTA_W];
    cmd_new.neg_y = dy_sat[DELTA_W];
    cmd_new.ax = dx_abs[MAG_W-1:0];
    cmd_new.ay = dy_abs[MAG_W-1:0];
    if (dx_sat == '0) begin
      cmd_new.mode = MODE_VERT;
    end else if (dy_sat == '0) begin
      cmd_new.mode = MODE_HORZ;
    end else begin
      cmd_new.mode = MODE_DIAG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_vld <= 1'b0;
    end else if (s_tready) begin
      cmd_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= cmd_new;
    end
  end

endmodule

// ----- sv/ltc_cmd_fifo.sv -----
module ltc_cmd_fifo (
  input  logic clk,
  input  logic rst,
  input  logic push_vld,
  output logic push_rdy,
  input  ltc_pkg::ltc_cmd_t push_cmd,
  output logic pop_vld,
  input  logic pop,
  output ltc_pkg::ltc_cmd_t pop_cmd
);
  import ltc_pkg::*;

  ltc_cmd_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic do_push;
  logic do_pop;

  assign push_rdy = (count != 2'd2);
  assign pop_vld = (count != 2'd0);
  assign pop_cmd = slots[rd_ptr];
  assign do_push = push_vld && push_rdy;
  assign do_pop = pop && pop_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- sv/ltc_walker.sv -----
module ltc_walker (
  input  logic clk,
  input  logic rst,
  input  logic cmd_vld,
  output logic cmd_pop,
  input  ltc_pkg::ltc_cmd_t cmd_in,
  output logic m_tvalid,
  input  logic m_tready,
  // cell_x [10:0], cell_y [21:11], zero fill
  output logic [ltc_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic m_tlast
);
  import ltc_pkg::*;

  ltc_walk_state_t state;
  ltc_walk_state_t state_next;
  ltc_cmd_t cmd;
  logic [MAG_W-1:0] col;
  logic [MAG_W-1:0] col_next;
  logic [MAG_W-1:0] row;
  logic [MAG_W-1:0] row_next;
  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W-1:0] err_next;
  logic signed [ERR_W-1:0] two_ax;
  logic signed [ERR_W-1:0] two_ay;
  logic signed [ERR_W-1:0] step_err;
  logic adv;
  logic emit;
  logic last;
  logic load;
  logic exact;
  logic signed [CELL_W-1:0] base_x;
  logic signed [CELL_W-1:0] base_y;
  logic signed [CELL_W-1:0] off_x;
  logic signed [CELL_W-1:0] off_y;
  logic signed [CELL_W-1:0] cell_x;
  logic signed [CELL_W-1:0] cell_y;

  assign adv = !m_tvalid || m_tready;
  assign two_ax = signed'(ERR_W'({cmd.ax, 1'b0}));
  assign two_ay = signed'(ERR_W'({cmd.ay, 1'b0}));
  assign step_err = err + two_ax;

  assign base_x = {cmd.start_x[COORD_W-1], cmd.start_x};
  assign base_y = {cmd.start_y[COORD_W-1], cmd.start_y};
  assign off_x = signed'(CELL_W'(col));
  assign off_y = signed'(CELL_W'(row));
  assign cell_x = cmd.neg_x ? base_x - off_x : base_x + off_x;
  assign cell_y = cmd.neg_y ? base_y - off_y : base_y + off_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= WALK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop = 1'b0;
    load = 1'b0;
    emit = 1'b0;
    last = 1'b0;
    exact = 1'b0;
    col_next = col;
    row_next = row;
    err_next = err;
    unique case (state)
      WALK_IDLE: begin
        if (cmd_vld) begin
          cmd_pop = 1'b1;
          load = 1'b1;
          state_next = WALK_RUN;
        end
      end
      WALK_RUN: begin
        if (adv) begin
          emit = 1'b1;
          unique case (cmd.mode)
            MODE_VERT: begin
              last = (row == cmd.ay);
              row_next = row + MAG_W'(1);
            end
            MODE_HORZ: begin
              last = (col == cmd.ax);
              col_next = col + MAG_W'(1);
            end
            default: begin
              if (col == cmd.ax) begin
                last = (row == cmd.ay);
                row_next = row + MAG_W'(1);
              end else if (step_err <= 0) begin
                row_next = row + MAG_W'(1);
                err_next = step_err;
              end else begin
                // Next column starts one row lower when the crossing hits a corner exactly.
                exact = (err == '0);
                col_next = col + MAG_W'(1);
                row_next = row - MAG_W'(exact);
                err_next = exact ? err - two_ay - two_ax : err - two_ay;
              end
            end
          endcase
          if (last) begin
            state_next = WALK_IDLE;
          end
        end
      end
      default: begin
        state_next = WALK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd <= cmd_in;
      col <= '0;
      row <= '0;
      err <= -(signed'(ERR_W'(cmd_in.ax)) + signed'(ERR_W'(cmd_in.ay)));
    end else begin
      col <= col_next;
      row <= row_next;
      err <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {(OUT_DATA_W - 2*CELL_W)'(0), cell_y, cell_x};
      m_tlast <= last;
    end
  end

endmodule

// ----- sv/line_touched_cells_core.sv -----
// Each move is classified into the front register, queued, then loaded into the walker,
// which emits one touched cell per cycle while the output is not stalled.
// The cell walker is the rate limit; a two-entry command queue lets the front accept
// the next move while the walker is busy; cells leave through an output register.
// Reset (rst, synchronous) empties the queue and drops any move in progress.
module line_touched_cells_core #(
  parameter int MAX_STEP = 15
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // start_x [9:0], start_y [19:10], delta_x [24:20], delta_y [29:25], zero fill
  input  logic [ltc_pkg::IN_DATA_W-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // cell_x [10:0], cell_y [21:11], zero fill
  output logic [ltc_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic m_tlast
);
  import ltc_pkg::*;

  logic front_vld;
  logic front_rdy;
  ltc_cmd_t front_cmd;
  logic queue_vld;
  logic queue_pop;
  ltc_cmd_t queue_cmd;

  ltc_front #(
    .MAX_STEP(MAX_STEP)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .cmd_vld(front_vld),
    .cmd_rdy(front_rdy),
    .cmd(front_cmd)
  );

  ltc_cmd_fifo u_queue (
    .clk(clk),
    .rst(rst),
    .push_vld(front_vld),
    .push_rdy(front_rdy),
    .push_cmd(front_cmd),
    .pop_vld(queue_vld),
    .pop(queue_pop),
    .pop_cmd(queue_cmd)
  );

  ltc_walker u_walker (
    .clk(clk),
    .rst(rst),
    .cmd_vld(queue_vld),
    .cmd_pop(queue_pop),
    .cmd_in(queue_cmd),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

endmodule
